FILE: sv/vacuum_friction_force_defines.svh
// Assertion macros shared by the friction force block.
`ifndef VACUUM_FRICTION_FORCE_DEFINES_SVH
`define VACUUM_FRICTION_FORCE_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain clocked check, off while reset is held.
`define VFF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vff: assertion failed");

// Check that applies only while a stage holds a valid item.
`define VFF_ASSERT_VLD(lbl, clk, rst_n, vld, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
        else $error("vff: assertion failed on valid item");

`else

`define VFF_ASSERT(lbl, clk, rst_n, prop)
`define VFF_ASSERT_VLD(lbl, clk, rst_n, vld, prop)

`endif

`endif

FILE: sv/vff_pkg.sv
package vff_pkg;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        REG_EDGE_AREA       = 3'd0,
        REG_CENTER_AREA     = 3'd1,
        REG_FRICTION_COEFF  = 3'd2,
        REG_SHEET_THICKNESS = 3'd3,
        REG_SHEET_STIFFNESS = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic        [22:0] edge_vacuum_pct;
        logic        [22:0] center_vacuum_pct;
        logic signed [31:0] sheet_height;
        logic signed [31:0] force_in_x;
        logic signed [31:0] force_in_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_out_x;
        logic signed [31:0] force_out_y;
        logic signed [31:0] force_out_z;
        logic               is_sliding;
    } t_out;

    typedef struct packed {
        logic [23:0] edge_area;
        logic [23:0] center_area;
        logic [19:0] friction_coeff;
        logic [16:0] sheet_thickness;
        logic [30:0] sheet_stiffness;
    } t_cfg;

    // Per-item data carried alongside the root and divide pipelines
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic        [40:0] fmag;
        logic               fneg;
        logic signed [31:0] zval;
        logic               below;
        logic               sszero;
    } t_side;

    // One atmosphere in hPa
    localparam int unsigned ATM_PA = 1013;
    // Friction limit magnitude cap, 2^40
    localparam logic [40:0] FLIM = 41'h100_0000_0000;

    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STEPS      = 32;
    localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fff_ffff;
        end else if (v < S32_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/vff_front.sv
`include "vacuum_friction_force_defines.svh"

// Force law front end: normal, sheet and limit forces, |f|^2 and the
// below-limit decision. Six register stages under one shared enable.
module vff_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  vff_pkg::t_in    i_in,
    input  vff_pkg::t_cfg   i_cfg,
    output logic            o_vld,
    output logic [63:0]     o_ss,
    output vff_pkg::t_side  o_side
);
    import vff_pkg::*;

    // stage 1
    logic               r1_vld;
    logic [46:0]        r1_pe, r1_pc;
    logic [32:0]        r1_dmag;
    logic               r1_dneg;
    logic [31:0]        r1_ax, r1_ay;
    logic signed [31:0] r1_fx, r1_fy;
    // stage 2
    logic               r2_vld;
    logic [47:0]        r2_nvmag;
    logic [56:0]        r2_ne, r2_nc;
    logic [63:0]        r2_sx, r2_sy;
    logic               r2_dneg;
    logic signed [31:0] r2_fx, r2_fy;
    // stage 3
    logic               r3_vld;
    logic [67:0]        r3_fprod;
    logic [63:0]        r3_ss;
    logic [41:0]        r3_n;
    logic [47:0]        r3_nvmag;
    logic               r3_dneg;
    logic signed [31:0] r3_fx, r3_fy;
    // stage 4
    logic               r4_vld;
    logic [40:0]        r4_fmag;
    logic               r4_fneg;
    logic signed [31:0] r4_zval;
    logic [63:0]        r4_ss;
    logic signed [31:0] r4_fx, r4_fy;
    // stage 5
    logic               r5_vld;
    logic [63:0]        r5_fsq;
    logic               r5_nolim, r5_big;
    logic [40:0]        r5_fmag;
    logic               r5_fneg;
    logic signed [31:0] r5_zval;
    logic [63:0]        r5_ss;
    logic signed [31:0] r5_fx, r5_fy;
    // stage 6
    logic               r6_vld;
    logic [63:0]        r6_ss;
    t_side              r6_side;

    logic signed [33:0] n_d;
    logic [63:0]        n_kprod;
    logic [57:0]        n_nsum;
    logic [51:0]        n_fsh;
    logic signed [49:0] n_nv;
    logic signed [50:0] n_diff;

    always_comb begin
        n_d     = $signed({17'b0, i_cfg.sheet_thickness}) - 34'(i_in.sheet_height);
        n_kprod = 64'(r1_dmag) * 64'(i_cfg.sheet_stiffness);
        n_nsum  = 58'(r2_ne) + 58'(r2_nc);
        n_fsh   = r3_fprod[67:16];
        n_nv    = r3_dneg ? -$signed({2'b0, r3_nvmag}) : $signed({2'b0, r3_nvmag});
        n_diff  = 51'(n_nv) - $signed({9'b0, r3_n});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // 1: suction products, sheet compression, force magnitudes
            r1_pe   <= 47'(i_in.edge_vacuum_pct) * 47'(i_cfg.edge_area);
            r1_pc   <= 47'(i_in.center_vacuum_pct) * 47'(i_cfg.center_area);
            r1_dmag <= n_d[33] ? 33'(-n_d) : 33'(n_d);
            r1_dneg <= n_d[33];
            r1_ax   <= i_in.force_in_x[31] ? 32'(-i_in.force_in_x) : 32'(i_in.force_in_x);
            r1_ay   <= i_in.force_in_y[31] ? 32'(-i_in.force_in_y) : 32'(i_in.force_in_y);
            r1_fx   <= i_in.force_in_x;
            r1_fy   <= i_in.force_in_y;
            // 2: sheet force, atmosphere scaling, squares
            r2_nvmag <= n_kprod[63:16];
            r2_ne    <= 57'(r1_pe) * 57'(ATM_PA);
            r2_nc    <= 57'(r1_pc) * 57'(ATM_PA);
            r2_sx    <= 64'(r1_ax) * 64'(r1_ax);
            r2_sy    <= 64'(r1_ay) * 64'(r1_ay);
            r2_dneg  <= r1_dneg;
            r2_fx    <= r1_fx;
            r2_fy    <= r1_fy;
            // 3: friction product, |f|^2, normal force
            r3_fprod <= 68'(r2_nvmag) * 68'(i_cfg.friction_coeff);
            r3_ss    <= r2_sx + r2_sy;
            r3_n     <= n_nsum[57:16];
            r3_nvmag <= r2_nvmag;
            r3_dneg  <= r2_dneg;
            r3_fx    <= r2_fx;
            r3_fy    <= r2_fy;
            // 4: limit saturation, vertical output
            r4_fmag  <= (n_fsh > {11'b0, FLIM}) ? FLIM : n_fsh[40:0];
            r4_fneg  <= r3_dneg && (n_fsh != '0);
            r4_zval  <= sat32(64'(n_diff));
            r4_ss    <= r3_ss;
            r4_fx    <= r3_fx;
            r4_fy    <= r3_fy;
            // 5: limit squared
            r5_fsq   <= 64'(r4_fmag[31:0]) * 64'(r4_fmag[31:0]);
            r5_nolim <= r4_fneg || (r4_fmag == '0);
            r5_big   <= |r4_fmag[40:32];
            r5_fmag  <= r4_fmag;
            r5_fneg  <= r4_fneg;
            r5_zval  <= r4_zval;
            r5_ss    <= r4_ss;
            r5_fx    <= r4_fx;
            r5_fy    <= r4_fy;
            // 6: below-limit decision
            r6_ss           <= r5_ss;
            r6_side.fx      <= r5_fx;
            r6_side.fy      <= r5_fy;
            r6_side.fmag    <= r5_fmag;
            r6_side.fneg    <= r5_fneg;
            r6_side.zval    <= r5_zval;
            r6_side.below   <= !r5_nolim && (r5_big || (r5_ss < r5_fsq));
            r6_side.sszero  <= (r5_ss == '0);
        end
    end

    assign o_vld  = r6_vld;
    assign o_ss   = r6_ss;
    assign o_side = r6_side;

    `VFF_ASSERT_VLD(a_fmag_cap, i_clk, i_rst_n, r4_vld, r4_fmag <= FLIM)
    `VFF_ASSERT_VLD(a_fneg_nonzero, i_clk, i_rst_n, r4_vld, !r4_fneg || (r4_fmag != '0))
    `VFF_ASSERT_VLD(a_below_pos, i_clk, i_rst_n, r6_vld, !r6_side.below || !r6_side.fneg)

endmodule

FILE: sv/vff_sqrt.sv
// Pipelined integer square root of |f|^2, two bit pairs per stage.
module vff_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [63:0]     i_ss,
    input  vff_pkg::t_side  i_side,
    output logic            o_vld,
    output logic [31:0]     o_p,
    output vff_pkg::t_side  o_side
);
    import vff_pkg::*;

    logic        r_vld  [SQRT_STAGES];
    logic [63:0] r_v    [SQRT_STAGES];
    logic [63:0] r_r    [SQRT_STAGES];
    t_side       r_side [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_st
        logic        vld_in;
        logic [63:0] v_in, r_in;
        t_side       side_in;
        logic [63:0] n_v, n_r, bitv;

        if (s == 0) begin : g_first
            assign vld_in  = i_vld;
            assign v_in    = i_ss;
            assign r_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign v_in    = r_v[s-1];
            assign r_in    = r_r[s-1];
            assign side_in = r_side[s-1];
        end

        // digit-by-digit root steps
        always_comb begin
            n_v  = v_in;
            n_r  = r_in;
            bitv = '0;
            for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                bitv = 64'(1) << (62 - 2 * (s * STEPS_PER_STAGE + i));
                if (n_v >= n_r + bitv) begin
                    n_v = n_v - (n_r + bitv);
                    n_r = (n_r >> 1) + bitv;
                end else begin
                    n_r = n_r >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[s]    <= n_v;
                r_r[s]    <= n_r;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_p    = r_r[SQRT_STAGES-1][31:0];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule

FILE: sv/vff_div.sv
`include "vacuum_friction_force_defines.svh"

// Capped components: F*|f|/P for x and y through a pipelined restoring
// divider, then sign, saturation and result selection into the output register.
module vff_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [31:0]     i_p,
    input  vff_pkg::t_side  i_side,
    output logic            o_vld,
    output vff_pkg::t_out   o_out
);
    import vff_pkg::*;

    // product stages
    logic        r0_vld, r1_vld;
    logic [63:0] r0_pl [2];
    logic [40:0] r0_ph [2];
    logic [40:0] r1_hi [2];
    logic [31:0] r1_lo [2];
    logic [31:0] r0_p, r1_p;
    t_side       r0_side, r1_side;

    // divide stages
    logic        r_vld  [DIV_STAGES];
    logic [31:0] r_rem  [DIV_STAGES][2];
    logic [31:0] r_lo   [DIV_STAGES][2];
    logic [31:0] r_q    [DIV_STAGES][2];
    logic        r_cap  [DIV_STAGES][2];
    logic [31:0] r_p    [DIV_STAGES];
    t_side       r_side [DIV_STAGES];

    // output register
    logic        r_out_vld;
    t_out        r_out;

    logic [31:0] n_ac  [2];
    logic [72:0] n_prd [2];

    always_comb begin
        n_ac[0]  = i_side.fx[31] ? 32'(-i_side.fx) : 32'(i_side.fx);
        n_ac[1]  = i_side.fy[31] ? 32'(-i_side.fy) : 32'(i_side.fy);
        for (int c = 0; c < 2; c++) begin
            n_prd[c] = {r0_ph[c], 32'b0} + 73'(r0_pl[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
        end
    end

    // limit times component, split into 32x32 and 9x32 parts, then summed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 2; c++) begin
                r0_pl[c] <= 64'(i_side.fmag[31:0]) * 64'(n_ac[c]);
                r0_ph[c] <= 41'(i_side.fmag[40:32]) * 41'(n_ac[c]);
                r1_hi[c] <= n_prd[c][72:32];
                r1_lo[c] <= n_prd[c][31:0];
            end
            r0_p    <= i_p;
            r0_side <= i_side;
            r1_p    <= r0_p;
            r1_side <= r0_side;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic        vld_in;
        logic [31:0] p_in;
        t_side       side_in;
        logic [31:0] rem_in [2];
        logic [31:0] lo_in  [2];
        logic [31:0] q_in   [2];
        logic        cap_in [2];
        logic [31:0] n_rem  [2];
        logic [31:0] n_lo   [2];
        logic [31:0] n_q    [2];
        logic [32:0] trial;

        if (s == 0) begin : g_first
            assign vld_in  = r1_vld;
            assign p_in    = r1_p;
            assign side_in = r1_side;
            // quotient would reach 2^32 or more when the high word reaches the divisor
            for (genvar c = 0; c < 2; c++) begin : g_c
                assign rem_in[c] = r1_hi[c][31:0];
                assign lo_in[c]  = r1_lo[c];
                assign q_in[c]   = '0;
                assign cap_in[c] = (r1_hi[c] >= {9'b0, r1_p});
            end
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign p_in    = r_p[s-1];
            assign side_in = r_side[s-1];
            for (genvar c = 0; c < 2; c++) begin : g_c
                assign rem_in[c] = r_rem[s-1][c];
                assign lo_in[c]  = r_lo[s-1][c];
                assign q_in[c]   = r_q[s-1][c];
                assign cap_in[c] = r_cap[s-1][c];
            end
        end

        // restoring division, one quotient bit per step
        always_comb begin
            trial = '0;
            for (int c = 0; c < 2; c++) begin
                n_rem[c] = rem_in[c];
                n_lo[c]  = lo_in[c];
                n_q[c]   = q_in[c];
                for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                    trial    = {n_rem[c], n_lo[c][31]};
                    n_lo[c]  = {n_lo[c][30:0], 1'b0};
                    if (trial >= {1'b0, p_in}) begin
                        n_rem[c] = 32'(trial - {1'b0, p_in});
                        n_q[c]   = {n_q[c][30:0], 1'b1};
                    end else begin
                        n_rem[c] = trial[31:0];
                        n_q[c]   = {n_q[c][30:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 2; c++) begin
                    r_rem[s][c] <= n_rem[c];
                    r_lo[s][c]  <= n_lo[c];
                    r_q[s][c]   <= n_q[c];
                    r_cap[s][c] <= cap_in[c];
                end
                r_p[s]    <= p_in;
                r_side[s] <= side_in;
            end
        end
    end

    // sign, saturation and branch selection
    t_side              n_fs;
    logic [32:0]        n_qf  [2];
    logic signed [33:0] n_sv  [2];
    logic               n_neg [2];
    logic signed [31:0] n_cap [2];
    t_out               n_out;

    always_comb begin
        n_fs     = r_side[DIV_STAGES-1];
        n_neg[0] = (n_fs.fneg == n_fs.fx[31]);
        n_neg[1] = (n_fs.fneg == n_fs.fy[31]);
        for (int c = 0; c < 2; c++) begin
            n_qf[c]  = r_cap[DIV_STAGES-1][c] ? 33'h1_0000_0000
                                              : {1'b0, r_q[DIV_STAGES-1][c]};
            n_sv[c]  = n_neg[c] ? -$signed({1'b0, n_qf[c]}) : $signed({1'b0, n_qf[c]});
            n_cap[c] = sat32(64'(n_sv[c]));
        end
        n_out.force_out_z = n_fs.zval;
        if (n_fs.sszero) begin
            n_out.force_out_x = '0;
            n_out.force_out_y = '0;
            n_out.is_sliding  = 1'b0;
        end else if (n_fs.below) begin
            n_out.force_out_x = sat32(-64'(n_fs.fx));
            n_out.force_out_y = sat32(-64'(n_fs.fy));
            n_out.is_sliding  = 1'b0;
        end else begin
            n_out.force_out_x = n_cap[0];
            n_out.force_out_y = n_cap[1];
            n_out.is_sliding  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_vld = r_out_vld;
    assign o_out = r_out;

    `VFF_ASSERT(a_stall_hold, i_clk, i_rst_n, (r_out_vld && !i_en) |=> (r_out_vld && $stable(r_out)))

endmodule

FILE: sv/vacuum_friction_force.sv
// Vacuum sheet friction force.
// Input channel (i_in_valid / o_in_ready / i_in): one transfer per sample of
// vacuum levels, sheet height and planar force. Output channel (o_out_valid /
// i_out_ready / o_out): one transfer per sample with the applied friction
// force, the vertical force and the sliding flag, in input order.
// Configuration channel (i_cfg_valid / o_cfg_ready, index, data): always ready,
// but the user must write it only while no sample is in flight; the block does
// not enforce this. Unknown indexes are ignored. The pipeline has 6 front
// stages, 16 square-root, 2 product, 16 divide, then the output register.
// Throughput: one sample per cycle while not stalled; the root and divider
// units take two result bits per stage, so their 32-bit results set the depth.
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops;
// nothing is dropped or repeated, and input is taken again once the
// output transfer completes.
module vacuum_friction_force (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vff_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output vff_pkg::t_out  o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import vff_pkg::*;

    t_cfg        r_cfg;
    logic        en;
    logic        f_vld, s_vld;
    logic [63:0] f_ss;
    t_side       f_side, s_side;
    logic [31:0] s_p;

    // pipeline advances unless a finished result is held
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EDGE_AREA:       r_cfg.edge_area       <= i_cfg_data[23:0];
                REG_CENTER_AREA:     r_cfg.center_area     <= i_cfg_data[23:0];
                REG_FRICTION_COEFF:  r_cfg.friction_coeff  <= i_cfg_data[19:0];
                REG_SHEET_THICKNESS: r_cfg.sheet_thickness <= i_cfg_data[16:0];
                REG_SHEET_STIFFNESS: r_cfg.sheet_stiffness <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    vff_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_vld   (f_vld),
        .o_ss    (f_ss),
        .o_side  (f_side)
    );

    vff_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_ss    (f_ss),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_p     (s_p),
        .o_side  (s_side)
    );

    vff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_p     (s_p),
        .i_side  (s_side),
        .o_vld   (o_out_valid),
        .o_out   (o_out)
    );

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vff_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         DRAIN_CYCLES = 60;

    typedef struct {
        t_in  x;
        bit   typed;
        t_out want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // shadow copy of the configuration registers
    logic [23:0] cfg_edge_area;
    logic [23:0] cfg_center_area;
    logic [19:0] cfg_mu;
    logic [16:0] cfg_thick;
    logic [30:0] cfg_stiff;

    t_out expected_forces[$];
    t_row directed_rows[$];
    int   n_errors = 0;
    bit   quiet = 1'b0;

    vacuum_friction_force uut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #8_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fff_ffff;
        if (v < -128'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // planar component when capped at the friction limit
    function automatic logic signed [31:0] capped_part(logic [127:0] fmag, logic fneg,
                                                       logic signed [31:0] c,
                                                       logic [127:0] p);
        logic [127:0]        cm;
        logic [127:0]        q;
        logic signed [127:0] v;
        cm = c[31] ? 128'(-{{96{c[31]}}, c}) : 128'(c);
        q  = (fmag * cm) / p;
        if (q > (128'd1 << 32)) q = 128'd1 << 32;
        v = (fneg == c[31]) ? -$signed(q) : $signed(q);
        return clamp32(v);
    endfunction

    // friction law: suction, sheet force, limit and planar clamp
    function automatic t_out friction_law(t_in x);
        logic [127:0]        suction, dm, nvmag, fmag, ax, ay, ss, root, trial;
        logic signed [127:0] d, nv;
        logic                fneg, below;
        t_out                r;
        suction = (128'(x.edge_vacuum_pct) * 128'd1013 * 128'(cfg_edge_area) +
                   128'(x.center_vacuum_pct) * 128'd1013 * 128'(cfg_center_area)) >> 16;
        d     = $signed({111'd0, cfg_thick}) - {{96{x.sheet_height[31]}}, x.sheet_height};
        dm    = d[127] ? 128'(-d) : 128'(d);
        nvmag = (dm * 128'(cfg_stiff)) >> 16;
        fmag  = (nvmag * 128'(cfg_mu)) >> 16;
        if (fmag > (128'd1 << 40)) fmag = 128'd1 << 40;
        fneg  = d[127] && (fmag != 0);
        nv    = d[127] ? -$signed(nvmag) : $signed(nvmag);
        r.force_out_z = clamp32(nv - $signed(suction));
        ax = x.force_in_x[31] ? 128'(-{{96{x.force_in_x[31]}}, x.force_in_x})
                              : 128'(x.force_in_x);
        ay = x.force_in_y[31] ? 128'(-{{96{x.force_in_y[31]}}, x.force_in_y})
                              : 128'(x.force_in_y);
        ss = ax * ax + ay * ay;
        r.is_sliding  = 1'b0;
        r.force_out_x = '0;
        r.force_out_y = '0;
        if (ss != 0) begin
            if (fneg || fmag == 0) below = 1'b0;
            else if (fmag >= (128'd1 << 32)) below = 1'b1;
            else below = ss < fmag * fmag;
            if (below) begin
                r.force_out_x = clamp32(-{{96{x.force_in_x[31]}}, x.force_in_x});
                r.force_out_y = clamp32(-{{96{x.force_in_y[31]}}, x.force_in_y});
            end else begin
                root = '0;
                for (int i = 31; i >= 0; i--) begin
                    trial = root | (128'd1 << i);
                    if (trial * trial <= ss) root = trial;
                end
                r.force_out_x = capped_part(fmag, fneg, x.force_in_x, root);
                r.force_out_y = capped_part(fmag, fneg, x.force_in_y, root);
                r.is_sliding  = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    initial begin
        int g;
        forever begin
            g = gap_len();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_forces.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, o_out);
                n_errors++;
            end else begin
                w = expected_forces.pop_front();
                if (o_out.force_out_x !== w.force_out_x) begin
                    $display("%0t: force_out_x exp %0d got %0d", $time,
                             w.force_out_x, o_out.force_out_x);
                    n_errors++;
                end
                if (o_out.force_out_y !== w.force_out_y) begin
                    $display("%0t: force_out_y exp %0d got %0d", $time,
                             w.force_out_y, o_out.force_out_y);
                    n_errors++;
                end
                if (o_out.force_out_z !== w.force_out_z) begin
                    $display("%0t: force_out_z exp %0d got %0d", $time,
                             w.force_out_z, o_out.force_out_z);
                    n_errors++;
                end
                if (o_out.is_sliding !== w.is_sliding) begin
                    $display("%0t: is_sliding exp %0b got %0b", $time,
                             w.is_sliding, o_out.is_sliding);
                    n_errors++;
                end
            end
        end
    end

    // one input transfer, then an optional gap
    task automatic send_sample(t_in x, bit typed, t_out want);
        int g;
        i_in       <= x;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_forces.insert(expected_forces.size(), typed ? want : friction_law(x));
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_forces.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_EDGE_AREA:       cfg_edge_area   = val[23:0];
            REG_CENTER_AREA:     cfg_center_area = val[23:0];
            REG_FRICTION_COEFF:  cfg_mu          = val[19:0];
            REG_SHEET_THICKNESS: cfg_thick       = val[16:0];
            REG_SHEET_STIFFNESS: cfg_stiff       = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_friction(logic [31:0] ea, logic [31:0] ca, logic [31:0] mu,
                                logic [31:0] th, logic [31:0] k);
        write_reg(REG_EDGE_AREA, ea);
        write_reg(REG_CENTER_AREA, ca);
        write_reg(REG_FRICTION_COEFF, mu);
        write_reg(REG_SHEET_THICKNESS, th);
        write_reg(REG_SHEET_STIFFNESS, k);
        write_reg(REG_UNUSED, $urandom);
    endtask

    function automatic t_in mk(logic [22:0] ev, logic [22:0] cv, logic [31:0] h,
                               logic [31:0] fx, logic [31:0] fy);
        t_in x;
        x.edge_vacuum_pct   = ev;
        x.center_vacuum_pct = cv;
        x.sheet_height      = h;
        x.force_in_x        = fx;
        x.force_in_y        = fy;
        return x;
    endfunction

    function automatic void add_row(t_in x, bit typed, t_out want);
        t_row r;
        r.x     = x;
        r.typed = typed;
        r.want  = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic logic [31:0] rand_force();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h0;
            1: v = 32'h8000_0000;
            2: v = 32'h7fff_ffff;
            3, 4, 5: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [22:0] rand_pct();
        case ($urandom_range(0, 4))
            0: return 23'd0;
            1: return 23'd6553600;
            2: return 23'($urandom);
            default: return 23'($urandom_range(0, 6553600));
        endcase
    endfunction

    function automatic t_in rand_sample();
        logic [31:0] h;
        if ($urandom_range(0, 2) != 0)
            h = 32'(cfg_thick) + 32'($signed($urandom_range(0, 262143)) - 131072);
        else
            h = $urandom;
        return mk(rand_pct(), rand_pct(), h, rand_force(),
                  ($urandom_range(0, 9) == 0) ? 32'h0 : rand_force());
    endfunction

    task automatic random_burst(int count);
        t_out none;
        none = '0;
        repeat (count) send_sample(rand_sample(), 1'b0, none);
    endtask

    // stimulus
    initial begin
        t_out zero_out, slide_out;
        cfg_edge_area   = '0;
        cfg_center_area = '0;
        cfg_mu          = '0;
        cfg_thick       = '0;
        cfg_stiff       = '0;
        zero_out  = '0;
        slide_out = '0;
        slide_out.is_sliding = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all registers zero after reset: zero limit, so any force slides to nothing
        add_row(mk('0, '0, '0, '0, '0), 1'b1, zero_out);
        add_row(mk('1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1, slide_out);
        add_row(mk('1, 23'd6553600, 32'h7fff_ffff, 32'h7fff_ffff, '0), 1'b1, slide_out);
        add_row(mk(23'd6553600, '0, 32'h1, '0, 32'h7fff_ffff), 1'b1, slide_out);
        add_row(mk('0, '1, 32'hffff_ffff, 32'h1, 32'hffff_ffff), 1'b1, zero_out);
        directed_rows[4].want = slide_out;
        foreach (directed_rows[i])
            send_sample(directed_rows[i].x, directed_rows[i].typed, directed_rows[i].want);
        wait_idle();

        // 1 m2 cells, mu 1.0, 0.5 m sheet, 16384 N/m
        set_friction(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h8000, 32'h4000_0000);
        directed_rows.delete();
        add_row(mk(23'd6553600, 23'd3276800, '0, '0, '0), 1'b0, zero_out);
        add_row(mk(23'd6553600, 23'd6553600, '0, 32'd1000 << 16, -(32'd500 << 16)),
                1'b0, zero_out);
        add_row(mk('0, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0, zero_out);
        add_row(mk('0, '0, '0, 32'h8000_0000, 32'h1), 1'b0, zero_out);
        // sheet above its thickness: negative limit
        add_row(mk('1, '1, 32'h1_0000, 32'd300 << 16, 32'd400 << 16), 1'b0, zero_out);
        add_row(mk('1, '1, 32'h7fff_ffff, -(32'd3 << 16), 32'd4 << 16), 1'b0, zero_out);
        add_row(mk(23'h7f_ffff, 23'h7f_ffff, '0, 32'h1, 32'h0), 1'b0, zero_out);
        foreach (directed_rows[i])
            send_sample(directed_rows[i].x, 1'b0, zero_out);
        wait_idle();

        // stiffest sheet far below, then far above: huge limit, most negative force cancelled below
        set_friction(32'hff_ffff, 32'hff_ffff, 32'd655360, 32'h1_0000, 32'h7fff_ffff);
        send_sample(mk('0, '0, 32'h8000_0000, 32'h8000_0000, '0), 1'b0, zero_out);
        send_sample(mk('1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, zero_out);
        send_sample(mk('1, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000), 1'b0, zero_out);
        quiet = 1'b1;
        random_burst(200);
        quiet = 1'b0;
        wait_idle();

        set_friction(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h8000, 32'h4000_0000);
        random_burst(220);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            set_friction($urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(0, 16),
                         $urandom_range(0, 655360), $urandom_range(0, 65536),
                         $urandom >> $urandom_range(1, 24));
            random_burst(180);
            wait_idle();
        end

        set_friction('0, '0, '0, '0, '0);
        random_burst(80);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
